// File: design/crf_pkg.sv
// shared types and constants for the palette frequency ranking block
`timescale 1ns / 1ps
package crf_pkg;
   localparam int MAX_COLORS = 256;
   localparam int COUNT_BITS = 32;
   localparam int IDX_BITS   = $clog2(MAX_COLORS);
   localparam int LEN_BITS   = $clog2(MAX_COLORS + 1);

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_FINISH = 2'd1,
      KIND_READ   = 2'd2,
      KIND_REMAP  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RSP_FINISH = 2'd0,
      RSP_RANK   = 2'd1,
      RSP_PIXEL  = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      logic                  valid;
      logic [IDX_BITS-1:0]   pal;
      logic [COUNT_BITS-1:0] cnt;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } cell_ctrl_type;
endpackage

// File: design/crf_cell.sv
// one slot of the sorted insertion chain
`timescale 1ns / 1ps
module crf_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  crf_pkg::cell_ctrl_type ctrl,
   input  crf_pkg::entry_type     new_entry,
   input  crf_pkg::entry_type     left_entry,
   input  logic                   left_before,
   input  crf_pkg::entry_type     right_entry,
   output crf_pkg::entry_type     entry,
   output logic                   ahead
);
   import crf_pkg::*;

   entry_type entry_ff, entry_in;

   // new entry goes ahead of this slot when the slot is empty or strictly smaller
   assign ahead = !(entry_ff.valid && (entry_ff.cnt >= new_entry.cnt));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.insert) begin
         if (ahead && !left_before) begin
            entry_in = new_entry;
         end else if (ahead) begin
            entry_in = left_entry;
         end
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.pal <= entry_in.pal;
      entry_ff.cnt <= entry_in.cnt;
   end
endmodule

// File: design/colormap_rank_by_frequency.sv
// top level: count store, insertion chain, rank tables and transaction control
// load: no result; the block stays idle and can take another transaction
// rank read, pixel remap: result in the cycle after accept; busy until then, so no new request is taken
// finish: report after the chain is filled from the count store and drained into the rank tables,
// feeding the chain one count a cycle, then draining it one rank a cycle; busy throughout
// reset: synchronous, color_count 256, one kept color; results cannot be stalled
`timescale 1ns / 1ps
module colormap_rank_by_frequency (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [crf_pkg::IDX_BITS-1:0]       req_index,
   input  logic [crf_pkg::COUNT_BITS-1:0]     req_count,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_result_kind,
   output logic [crf_pkg::IDX_BITS-1:0]       rsp_color_index,
   output logic [crf_pkg::COUNT_BITS-1:0]     rsp_entry_count,
   output logic [crf_pkg::LEN_BITS-1:0]       rsp_used_colors,
   input  logic                               csr_write_enable,
   input  logic [crf_pkg::LEN_BITS-1:0]       csr_write_data
);
   import crf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_FILL   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_BITS-1:0]   color_count_ff;
   logic [LEN_BITS-1:0]   kept_ff;
   logic [LEN_BITS-1:0]   ranked_ff;
   logic [LEN_BITS-1:0]   len_ff;
   logic [LEN_BITS-1:0]   fill_ff;
   logic [LEN_BITS-1:0]   drain_ff;
   logic                  pend_ff;
   logic [IDX_BITS-1:0]   pend_idx_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [IDX_BITS+COUNT_BITS-1:0] rank_rd_ff;
   logic [IDX_BITS-1:0]   i2r_rd_ff;
   logic                  hit_ff;
   logic                  is_read_ff;

   logic [COUNT_BITS-1:0]          count_mem [MAX_COLORS];
   logic [IDX_BITS+COUNT_BITS-1:0] rank_mem  [MAX_COLORS];
   logic [IDX_BITS-1:0]            i2r_mem   [MAX_COLORS];

   logic                accept;
   logic [LEN_BITS-1:0] active_len;
   logic                fill_more;
   logic                drain_last;
   cell_ctrl_type       ctrl;
   entry_type           new_entry;
   entry_type           cell_entry  [MAX_COLORS];
   logic                cell_before [MAX_COLORS];
   entry_type           empty_entry;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      active_len = color_count_ff;
      if (color_count_ff == '0) begin
         active_len = LEN_BITS'(1);
      end else if (color_count_ff > LEN_BITS'(MAX_COLORS)) begin
         active_len = LEN_BITS'(MAX_COLORS);
      end
   end

   assign fill_more  = (fill_ff < len_ff);
   assign drain_last = (drain_ff == (len_ff - LEN_BITS'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (kind_type'(req_kind) != KIND_LOAD)) begin
               state_in = (kind_type'(req_kind) == KIND_FINISH) ? ST_FILL : ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_IDLE;
         ST_FILL: begin
            if (!fill_more && !pend_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_last) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // chain control and the entry offered for insertion
   assign ctrl.clear  = accept && (kind_type'(req_kind) == KIND_FINISH);
   assign ctrl.insert = (state_ff == ST_FILL) && pend_ff;
   assign ctrl.shift  = (state_ff == ST_DRAIN);
   assign new_entry   = '{valid: 1'b1, pal: pend_idx_ff, cnt: cnt_rd_ff};
   assign empty_entry = '{valid: 1'b0, pal: '0, cnt: '0};

   for (genvar g = 0; g < MAX_COLORS; g++) begin : g_cell
      crf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  ((g == 0) ? empty_entry : cell_entry[(g == 0) ? 0 : g - 1]),
         .left_before ((g == 0) ? 1'b0 : cell_before[(g == 0) ? 0 : g - 1]),
         .right_entry ((g == MAX_COLORS - 1) ? empty_entry
                       : cell_entry[(g == MAX_COLORS - 1) ? g : g + 1]),
         .entry       (cell_entry[g]),
         .ahead       (cell_before[g])
      );
   end

   // count store: written by loads, read one entry a cycle during fill
   always_ff @(posedge clock) begin
      if (accept && (kind_type'(req_kind) == KIND_LOAD)) begin
         count_mem[req_index] <= req_count;
      end
      cnt_rd_ff <= count_mem[fill_ff[IDX_BITS-1:0]];
   end

   // rank tables: written while draining, read by queries
   always_ff @(posedge clock) begin
      if (state_ff == ST_DRAIN) begin
         rank_mem[drain_ff[IDX_BITS-1:0]] <= {cell_entry[0].pal, cell_entry[0].cnt};
         i2r_mem[cell_entry[0].pal]       <= drain_ff[IDX_BITS-1:0];
      end
      rank_rd_ff <= rank_mem[req_index];
      i2r_rd_ff  <= i2r_mem[req_index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         color_count_ff <= LEN_BITS'(MAX_COLORS);
         kept_ff        <= LEN_BITS'(1);
         ranked_ff      <= '0;
         pend_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            color_count_ff <= csr_write_data;
         end
         if (ctrl.clear) begin
            kept_ff <= LEN_BITS'(1);
         end else if ((state_ff == ST_DRAIN) && (cell_entry[0].cnt != '0)) begin
            kept_ff <= drain_ff + LEN_BITS'(1);
         end
         if (state_ff == ST_REPORT) begin
            ranked_ff <= len_ff;
         end
         pend_ff <= (state_ff == ST_FILL) && fill_more;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         len_ff   <= active_len;
         fill_ff  <= '0;
         drain_ff <= '0;
      end else begin
         if ((state_ff == ST_FILL) && fill_more) begin
            fill_ff <= fill_ff + LEN_BITS'(1);
         end
         if (state_ff == ST_DRAIN) begin
            drain_ff <= drain_ff + LEN_BITS'(1);
         end
      end
      pend_idx_ff <= fill_ff[IDX_BITS-1:0];
      if (accept) begin
         hit_ff     <= ({1'b0, req_index} < ranked_ff);
         is_read_ff <= (kind_type'(req_kind) == KIND_READ);
      end
   end

   always_comb begin
      rsp_strobe      = 1'b0;
      rsp_result_kind = RSP_FINISH;
      rsp_color_index = '0;
      rsp_entry_count = '0;
      rsp_used_colors = kept_ff;
      if (state_ff == ST_REPORT) begin
         rsp_strobe = 1'b1;
      end else if (state_ff == ST_LOOKUP) begin
         rsp_strobe = 1'b1;
         if (is_read_ff) begin
            rsp_result_kind = RSP_RANK;
            if (hit_ff) begin
               rsp_color_index = rank_rd_ff[IDX_BITS+COUNT_BITS-1:COUNT_BITS];
               rsp_entry_count = rank_rd_ff[COUNT_BITS-1:0];
            end
         end else begin
            rsp_result_kind = RSP_PIXEL;
            if (hit_ff) begin
               rsp_color_index = i2r_rd_ff;
            end
         end
      end
   end

   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_used_colors != '0))
      else $error("used color count is zero");

   a_kept_in_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> (kept_ff <= len_ff))
      else $error("kept colors exceed ranked length");

   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind_type'(req_kind) == KIND_LOAD)) |=> !busy && !rsp_strobe)
      else $error("load left the block busy");

   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && ((kind_type'(req_kind) == KIND_READ) ||
                  (kind_type'(req_kind) == KIND_REMAP))) |=> rsp_strobe)
      else $error("query gave no result");
endmodule

// File: dv/tb_colormap_rank_by_frequency.sv
// testbench for the palette frequency ranking block: directed table, then random phases
`timescale 1ns / 1ps
module tb_colormap_rank_by_frequency;
   import crf_pkg::*;

   typedef struct packed {
      rsp_kind_type          kind;
      logic [IDX_BITS-1:0]   color;
      logic [COUNT_BITS-1:0] cnt;
      logic [LEN_BITS-1:0]   used;
   } rank_result_type;

   typedef struct packed {
      kind_type              kind;
      logic [IDX_BITS-1:0]   index;
      logic [COUNT_BITS-1:0] cnt;
      logic                  typed;
      rank_result_type       res;
   } stim_row_type;

   localparam int WATCHDOG_LIMIT = 5000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   logic [1:0]            req_kind = 0;
   logic [IDX_BITS-1:0]   req_index = 0;
   logic [COUNT_BITS-1:0] req_count = 0;
   logic                  rsp_strobe;
   logic [1:0]            rsp_result_kind;
   logic [IDX_BITS-1:0]   rsp_color_index;
   logic [COUNT_BITS-1:0] rsp_entry_count;
   logic [LEN_BITS-1:0]   rsp_used_colors;
   logic                  csr_write_enable = 0;
   logic [LEN_BITS-1:0]   csr_write_data = 0;

   // predictor state
   logic [COUNT_BITS-1:0] hist_counts [MAX_COLORS];
   logic [IDX_BITS-1:0]   rank_pal [MAX_COLORS];
   logic [COUNT_BITS-1:0] rank_cnt [MAX_COLORS];
   logic [IDX_BITS-1:0]   pal_rank [MAX_COLORS];
   int                    kept;
   int                    ranked;
   logic [LEN_BITS-1:0]   color_reg;

   rank_result_type pending_results[$];
   int              errors = 0;
   int              quiet_cycles = 0;
   int              idle_pct = 0;

   colormap_rank_by_frequency uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   function automatic int ranked_len_of(input logic [LEN_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_COLORS) return MAX_COLORS;
      return v;
   endfunction

   function automatic void rank_palette();
      int n;
      int r;
      n = ranked_len_of(color_reg);
      for (int i = 0; i < MAX_COLORS; i++) begin
         rank_pal[i] = 0;
         rank_cnt[i] = 0;
         pal_rank[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
         r = 0;
         for (int j = 0; j < n; j++)
            if (hist_counts[j] > hist_counts[i] ||
                (hist_counts[j] == hist_counts[i] && j < i)) r++;
         rank_pal[r] = IDX_BITS'(i);
         rank_cnt[r] = hist_counts[i];
         pal_rank[i] = IDX_BITS'(r);
      end
      kept = n;
      while (kept > 1 && rank_cnt[kept-1] == 0) kept--;
      ranked = n;
   endfunction

   // returns 1 when the transaction produces a result
   function automatic bit predict_rank(input kind_type k, input logic [IDX_BITS-1:0] idx,
                                       input logic [COUNT_BITS-1:0] c,
                                       output rank_result_type res);
      res = '0;
      case (k)
         KIND_LOAD: begin
            hist_counts[idx] = c;
            return 0;
         end
         KIND_FINISH: begin
            rank_palette();
            res.kind = RSP_FINISH;
         end
         KIND_READ: begin
            res.kind = RSP_RANK;
            if (idx < ranked) begin
               res.color = rank_pal[idx];
               res.cnt   = rank_cnt[idx];
            end
         end
         default: begin
            res.kind = RSP_PIXEL;
            if (idx < ranked) res.color = pal_rank[idx];
         end
      endcase
      res.used = LEN_BITS'(kept);
      return 1;
   endfunction

   task automatic send_item(input stim_row_type row);
      rank_result_type res;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start     <= 1;
      req_kind  <= row.kind;
      req_index <= row.index;
      req_count <= row.cnt;
      do @(posedge clock); while (busy);
      if (predict_rank(row.kind, row.index, row.cnt, res))
         pending_results.push_back(row.typed ? row.res : res);
      @(negedge clock);
   endtask

   task automatic send_op(input kind_type k, input logic [IDX_BITS-1:0] idx,
                          input logic [COUNT_BITS-1:0] c);
      stim_row_type row;
      row = '0;
      row.kind = k;
      row.index = idx;
      row.cnt = c;
      send_item(row);
   endtask

   task automatic write_color_count(input logic [LEN_BITS-1:0] v);
      start <= 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 0;
      color_reg = v;
   endtask

   function automatic logic [COUNT_BITS-1:0] pick_count();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2, 3: return COUNT_BITS'($urandom_range(3));
         4: return COUNT_BITS'(1) << $urandom_range(COUNT_BITS - 1);
         default: return COUNT_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [IDX_BITS-1:0] pick_index();
      if ($urandom_range(1)) return IDX_BITS'($urandom_range(kept > 1 ? kept - 1 : 0));
      return IDX_BITS'($urandom_range(MAX_COLORS - 1));
   endfunction

   always @(posedge clock) begin
      rank_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("unexpected result at %0t", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind)
               report_mismatch("result_kind", rsp_result_kind, want.kind);
            if (rsp_color_index !== want.color)
               report_mismatch("color_index", rsp_color_index, want.color);
            if (rsp_entry_count !== want.cnt)
               report_mismatch("entry_count", rsp_entry_count, want.cnt);
            if (rsp_used_colors !== want.used)
               report_mismatch("used_colors", rsp_used_colors, want.used);
         end
      end
   end

   // cycles with no transaction in either direction
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      stim_row_type directed[$];
      int n_queries;
      color_reg = LEN_BITS'(MAX_COLORS);
      kept = 1;
      ranked = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // every count written before any ranking
      for (int i = 0; i < MAX_COLORS; i++) send_op(KIND_LOAD, IDX_BITS'(i), '0);

      directed = '{
         '{KIND_LOAD,   8'd0,   32'hFFFF_FFFF, 1'b0, '0},
         '{KIND_LOAD,   8'd255, 32'd5,         1'b0, '0},
         '{KIND_LOAD,   8'd3,   32'd5,         1'b0, '0},
         '{KIND_FINISH, 8'd0,   32'd0, 1'b1, '{RSP_FINISH, 8'd0,   32'd0,         9'd3}},
         '{KIND_READ,   8'd0,   32'd0, 1'b1, '{RSP_RANK,   8'd0,   32'hFFFF_FFFF, 9'd3}},
         '{KIND_READ,   8'd1,   32'd0, 1'b1, '{RSP_RANK,   8'd3,   32'd5,         9'd3}},
         '{KIND_READ,   8'd2,   32'd0, 1'b1, '{RSP_RANK,   8'd255, 32'd5,         9'd3}},
         '{KIND_READ,   8'd255, 32'd0, 1'b0, '0},
         '{KIND_REMAP,  8'd255, 32'd0, 1'b1, '{RSP_PIXEL,  8'd2,   32'd0,         9'd3}},
         '{KIND_REMAP,  8'd1,   32'd0, 1'b1, '{RSP_PIXEL,  8'd3,   32'd0,         9'd3}},
         '{KIND_REMAP,  8'd0,   32'd0, 1'b0, '0},
         '{KIND_LOAD,   8'd0,   32'd0,         1'b0, '0},
         '{KIND_LOAD,   8'd3,   32'd0,         1'b0, '0},
         '{KIND_LOAD,   8'd255, 32'd0,         1'b0, '0},
         '{KIND_FINISH, 8'd0,   32'd0, 1'b1, '{RSP_FINISH, 8'd0,   32'd0,         9'd1}},
         '{KIND_READ,   8'd0,   32'd0, 1'b1, '{RSP_RANK,   8'd0,   32'd0,         9'd1}},
         '{KIND_REMAP,  8'd77,  32'd0, 1'b0, '0}
      };
      foreach (directed[i]) send_item(directed[i]);

      for (int p = 0; p < 16; p++) begin
         case (p % 4)
            0: idle_pct = 0;
            1: idle_pct = 61;
            2: idle_pct = 0;
            default: idle_pct = 23;
         endcase
         case (p)
            0: write_color_count(1);
            1: write_color_count(256);
            2: write_color_count(2);
            3: write_color_count(256);
            4: write_color_count(0);
            5: write_color_count(9'h1FF);
            6: write_color_count(255);
            default: write_color_count(LEN_BITS'($urandom_range(1, 40)));
         endcase
         // fill the whole palette with nonzero counts before this phase's random loads
         if (p == 3) begin
            for (int i = 0; i < MAX_COLORS; i++)
               send_op(KIND_LOAD, IDX_BITS'(i), $urandom | 1);
         end
         for (int s = 0; s < 4; s++) begin
            repeat ($urandom_range(8))
               send_op(KIND_LOAD, IDX_BITS'($urandom_range(MAX_COLORS - 1)), pick_count());
            send_op(KIND_FINISH, IDX_BITS'($urandom), $urandom);
            n_queries = $urandom_range(5, 14);
            repeat (n_queries)
               send_op($urandom_range(1) ? KIND_READ : KIND_REMAP, pick_index(), $urandom);
         end
         // noise: any kind in any order, finish a little more likely than the others
         repeat (12) send_op(kind_type'($urandom_range(9) == 0 ? KIND_FINISH :
                                        $urandom_range(3)),
                             IDX_BITS'($urandom), pick_count());
      end

      idle_pct = 0;
      start <= 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// File: files.f
design/crf_pkg.sv
design/crf_cell.sv
design/colormap_rank_by_frequency.sv
dv/tb_colormap_rank_by_frequency.sv
